// ----- design/rne_pkg.sv -----
// Shared types, constants and digit tables for the Roman numeral encoder.
// No dependencies; every other file in the design imports this package.
package rne_pkg;

   // Number of items that may be in flight between the request side and the sequencer.
   localparam int unsigned QDEPTH = 8;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // Largest value that has a numeral.
   localparam logic [11:0] MAX_VALUE = 12'd3999;

   // Decade steps used when splitting the value into decimal digits.
   localparam logic [11:0] STEP_THOU = 12'd1000;
   localparam logic [11:0] STEP_HUND = 12'd100;
   localparam logic [11:0] STEP_TENS = 12'd10;

   // ASCII codes of the numeral letters.
   localparam logic [6:0] SYM_I    = 7'h49;
   localparam logic [6:0] SYM_V    = 7'h56;
   localparam logic [6:0] SYM_X    = 7'h58;
   localparam logic [6:0] SYM_L    = 7'h4C;
   localparam logic [6:0] SYM_C    = 7'h43;
   localparam logic [6:0] SYM_D    = 7'h44;
   localparam logic [6:0] SYM_M    = 7'h4D;
   localparam logic [6:0] SYM_NONE = 7'h00;

   // Role of a letter within its decade.
   localparam logic [1:0] CODE_ONE  = 2'd0;
   localparam logic [1:0] CODE_FIVE = 2'd1;
   localparam logic [1:0] CODE_TEN  = 2'd2;

   // Decade indexes.
   localparam logic [1:0] DEC_UNITS = 2'd0;
   localparam logic [1:0] DEC_TENS  = 2'd1;
   localparam logic [1:0] DEC_HUND  = 2'd2;
   localparam logic [1:0] DEC_THOU  = 2'd3;

   // One classified item as it travels through the queue.
   typedef struct packed {
      logic       range_error;
      logic [3:0] thou;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] units;
   } item_type;

   // Result of peeling one decimal digit off a value.
   typedef struct packed {
      logic [3:0]  digit;
      logic [11:0] rem;
   } split_type;

   // Finds the digit of r at the given decade step by nine parallel compares
   // against constant thresholds, and the remainder below that step.
   function automatic split_type split_dec(input logic [11:0] r, input logic [11:0] step);
      split_type   res;
      logic [15:0] thr;
      res.digit = '0;
      res.rem   = r;
      thr       = '0;
      for (int k = 1; k <= 9; k++) begin
         thr = thr + {4'b0, step};
         if ({4'b0, r} >= thr) begin
            res.digit = 4'(k);
            res.rem   = r - thr[11:0];
         end
      end
      return res;
   endfunction

   // Number of letters a decimal digit takes in a numeral.
   function automatic logic [2:0] dig_len(input logic [3:0] d);
      logic [2:0] len;
      unique case (d)
         4'd1, 4'd5:               len = 3'd1;
         4'd2, 4'd4, 4'd6, 4'd9:   len = 3'd2;
         4'd3, 4'd7:               len = 3'd3;
         4'd8:                     len = 3'd4;
         default:                  len = 3'd0;
      endcase
      return len;
   endfunction

   // Role of the k-th letter of a digit, following the subtractive pattern.
   function automatic logic [1:0] dig_code(input logic [3:0] d, input logic [1:0] k);
      logic [1:0] code;
      unique case (d)
         4'd4:                   code = (k == 2'd0) ? CODE_ONE : CODE_FIVE;
         4'd9:                   code = (k == 2'd0) ? CODE_ONE : CODE_TEN;
         4'd5, 4'd6, 4'd7, 4'd8: code = (k == 2'd0) ? CODE_FIVE : CODE_ONE;
         default:                code = CODE_ONE;
      endcase
      return code;
   endfunction

   // Letter for a role within a decade; the thousands decade only has M.
   function automatic logic [6:0] dec_sym(input logic [1:0] decade, input logic [1:0] code);
      logic [6:0] sym;
      unique case (decade)
         DEC_UNITS: sym = (code == CODE_ONE) ? SYM_I : ((code == CODE_FIVE) ? SYM_V : SYM_X);
         DEC_TENS:  sym = (code == CODE_ONE) ? SYM_X : ((code == CODE_FIVE) ? SYM_L : SYM_C);
         DEC_HUND:  sym = (code == CODE_ONE) ? SYM_C : ((code == CODE_FIVE) ? SYM_D : SYM_M);
         default:   sym = SYM_M;
      endcase
      return sym;
   endfunction

endpackage

// ----- design/rne_front.sv -----
// Request side of the Roman numeral encoder: range check and decimal digit split.
// Depends on rne_pkg. Feeds rne_queue and tracks the items in flight.
module rne_front
   import rne_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [11:0] req_value,
   input  logic        pop,
   output logic        busy,
   output logic        push,
   output item_type    push_item
);

   logic              s0_valid_ff, s0_valid_in;
   logic [11:0]       s0_value_ff, s0_value_in;
   logic              s0_err_ff, s0_err_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [11:0]       s1_rem_ff, s1_rem_in;
   logic [3:0]        s1_thou_ff, s1_thou_in;
   logic              s1_err_ff, s1_err_in;
   logic              s2_valid_ff, s2_valid_in;
   logic [11:0]       s2_rem_ff, s2_rem_in;
   logic [3:0]        s2_thou_ff, s2_thou_in;
   logic [3:0]        s2_hund_ff, s2_hund_in;
   logic              s2_err_ff, s2_err_in;
   logic [QCNT_W-1:0] inflight_ff, inflight_in;
   logic              accept;
   split_type         thou_split;
   split_type         hund_split;
   split_type         tens_split;

   assign accept = start && !busy;
   assign busy   = (inflight_ff == QCNT_W'(QDEPTH));

   // Count items between acceptance and their hand-over to the sequencer.
   always_comb begin
      inflight_in = inflight_ff;
      if (accept && !pop) begin
         inflight_in = inflight_ff + QCNT_W'(1);
      end else if (pop && !accept) begin
         inflight_in = inflight_ff - QCNT_W'(1);
      end
   end

   // Stage 0 captures the value and flags values without a numeral.
   always_comb begin
      s0_valid_in = accept;
      s0_value_in = req_value;
      s0_err_in   = (req_value == 12'd0) || (req_value > MAX_VALUE);
   end

   // Stage 1 peels off the thousands digit.
   assign thou_split = split_dec(s0_value_ff, STEP_THOU);
   always_comb begin
      s1_valid_in = s0_valid_ff;
      s1_rem_in   = thou_split.rem;
      s1_thou_in  = thou_split.digit;
      s1_err_in   = s0_err_ff;
   end

   // Stage 2 peels off the hundreds digit.
   assign hund_split = split_dec(s1_rem_ff, STEP_HUND);
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_rem_in   = hund_split.rem;
      s2_thou_in  = s1_thou_ff;
      s2_hund_in  = hund_split.digit;
      s2_err_in   = s1_err_ff;
   end

   // Tens and units are split on the way into the queue.
   assign tens_split = split_dec(s2_rem_ff, STEP_TENS);
   always_comb begin
      push                  = s2_valid_ff;
      push_item.range_error = s2_err_ff;
      push_item.thou        = s2_thou_ff;
      push_item.hund        = s2_hund_ff;
      push_item.tens        = tens_split.digit;
      push_item.units       = tens_split.rem[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         inflight_ff <= '0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         inflight_ff <= inflight_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      s0_value_ff <= s0_value_in;
      s0_err_ff   <= s0_err_in;
      s1_rem_ff   <= s1_rem_in;
      s1_thou_ff  <= s1_thou_in;
      s1_err_ff   <= s1_err_in;
      s2_rem_ff   <= s2_rem_in;
      s2_thou_ff  <= s2_thou_in;
      s2_hund_ff  <= s2_hund_in;
      s2_err_ff   <= s2_err_in;
   end

endmodule

// ----- design/rne_queue.sv -----
// Short queue of classified items between the request side and the sequencer.
// Depends on rne_pkg for the item type and depth.
module rne_queue
   import rne_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     empty,
   output logic     full,
   output item_type head
);

   item_type          mem [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QDEPTH));
   assign head  = mem[rd_ptr_ff];

   // Pointer and fill level update; both sides may transfer in one cycle.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage is written at the write pointer.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- design/rne_back.sv -----
// Letter sequencer of the Roman numeral encoder: one letter per cycle.
// Depends on rne_pkg; takes items from rne_queue and drives the result ports.
module rne_back
   import rne_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  item_type   q_head,
   output logic       pop,
   output logic       rsp_valid,
   output logic [6:0] rsp_symbol,
   output logic       rsp_last,
   output logic       rsp_range_error
);

   logic       act_ff, act_in;
   item_type   item_ff, item_in;
   logic [3:0] mask_ff, mask_in;
   logic [1:0] k_ff, k_in;
   logic       valid_ff, valid_in;
   logic [6:0] symbol_ff, symbol_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;
   logic [1:0] decade;
   logic [3:0] digit;
   logic [2:0] len;
   logic       digit_end;
   logic [3:0] mask_next;
   logic       fin;

   // Highest decade that still has letters to send.
   always_comb begin
      priority if (mask_ff[3]) begin
         decade = DEC_THOU;
      end else if (mask_ff[2]) begin
         decade = DEC_HUND;
      end else if (mask_ff[1]) begin
         decade = DEC_TENS;
      end else begin
         decade = DEC_UNITS;
      end
   end

   always_comb begin
      unique case (decade)
         DEC_THOU: digit = item_ff.thou;
         DEC_HUND: digit = item_ff.hund;
         DEC_TENS: digit = item_ff.tens;
         default:  digit = item_ff.units;
      endcase
   end

   // Letter position within the digit and the end of the whole numeral.
   always_comb begin
      len       = dig_len(digit);
      digit_end = ({1'b0, k_ff} == (len - 3'd1));
      mask_next = mask_ff;
      if (digit_end) begin
         mask_next[decade] = 1'b0;
      end
      fin = act_ff && (item_ff.range_error || (digit_end && (mask_next == 4'd0)));
      pop = (!act_ff || fin) && !q_empty;
   end

   // Next sequencer state: load a new item as soon as the current one ends.
   always_comb begin
      act_in  = act_ff;
      item_in = item_ff;
      mask_in = mask_ff;
      k_in    = k_ff;
      if (pop) begin
         act_in  = 1'b1;
         item_in = q_head;
         mask_in = {q_head.thou != 4'd0, q_head.hund != 4'd0,
                    q_head.tens != 4'd0, q_head.units != 4'd0};
         k_in    = 2'd0;
      end else if (fin) begin
         act_in = 1'b0;
      end else if (act_ff) begin
         mask_in = mask_next;
         k_in    = digit_end ? 2'd0 : k_ff + 2'd1;
      end
   end

   // Registered result for the current letter.
   always_comb begin
      valid_in  = act_ff;
      symbol_in = item_ff.range_error ? SYM_NONE : dec_sym(decade, dig_code(digit, k_ff));
      last_in   = fin;
      err_in    = item_ff.range_error;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         act_ff   <= act_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      mask_ff   <= mask_in;
      k_ff      <= k_in;
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
      err_ff    <= err_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_symbol      = symbol_ff;
   assign rsp_last        = last_ff;
   assign rsp_range_error = err_ff;

endmodule

// ----- design/roman_numeral_encoder.sv -----
// Top level of the Roman numeral encoder.
// Depends on rne_pkg, rne_front, rne_queue and rne_back.

// A value is transferred at a rising edge where start is high and busy is low.
// Each value yields its numeral as one ASCII letter per cycle on rsp_symbol,
// strobed by rsp_valid, with rsp_last on the final letter; a value of 0 or
// above 3999 yields a single result with symbol 0, rsp_last and
// rsp_range_error set. A value passes the split stages, the queue and the
// sequencer registers before its first letter shows, then yields as many
// letters as its numeral has, from 1 to 15 (3888 is the longest), with no
// gap to the next value's letters when that value is already queued. The
// output letter sequencer sets the sustained rate. Up to eight values may be
// held between transfer and the sequencer; busy rises only when all are taken.
// Results cannot be held off: every strobed result must be taken in its cycle.
module roman_numeral_encoder
   import rne_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_value,
   output logic        rsp_valid,
   output logic [6:0]  rsp_symbol,
   output logic        rsp_last,
   output logic        rsp_range_error
);

   logic     push;
   item_type push_item;
   logic     pop;
   logic     q_empty;
   logic     q_full;
   item_type q_head;

   // Range check and decimal split.
   rne_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_value (req_value),
      .pop       (pop),
      .busy      (busy),
      .push      (push),
      .push_item (push_item)
   );

   // Decoupling queue.
   rne_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .empty     (q_empty),
      .full      (q_full),
      .head      (q_head)
   );

   // Letter sequencer and result registers.
   rne_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_symbol      (rsp_symbol),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error)
   );

`ifndef SYNTHESIS
   // The in-flight limit must keep the queue from ever overflowing.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full && !pop))
      else $error("queue written while full");

   // The sequencer never takes an item from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_empty))
      else $error("queue read while empty");

   // A flagged result stands alone: it ends its run and carries no letter.
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_last && (rsp_symbol == SYM_NONE)))
      else $error("flagged result not a lone empty result");

   // Every unflagged result is a real letter.
   a_letter: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_range_error) |-> (rsp_symbol != SYM_NONE))
      else $error("numeral result without a letter");

   // No result straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobed after reset");
`endif

endmodule

// ----- verif/roman_numeral_encoder_tb.sv -----
// Self-checking testbench for the Roman numeral encoder: directed values, then random
// values under several sender idling patterns, each letter checked, many by predictor.
// Depends on rne_pkg and roman_numeral_encoder.
`timescale 1ns / 100ps

module roman_numeral_encoder_tb;
   import rne_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int RESET_CYCLES     = 12;
   localparam int N_DIRECTED       = 22;
   localparam int N_PHASES         = 4;
   localparam int VALUES_PER_PHASE = 120;
   // Quiet period after the last expected letter, to catch stray letters.
   localparam int DRAIN_CYCLES     = 20;

   // Letters of each decade, units in the low seven bits; the thousands only have M.
   localparam logic [27:0] ONE_LETTERS  = {SYM_M, SYM_C, SYM_X, SYM_I};
   localparam logic [27:0] FIVE_LETTERS = {SYM_M, SYM_D, SYM_L, SYM_V};
   localparam logic [27:0] TEN_LETTERS  = {SYM_M, SYM_M, SYM_C, SYM_X};

   // How the expected letters of a directed row are obtained.
   typedef enum {ROW_PREDICT, ROW_NUMERAL, ROW_RANGE_ERROR} row_kind_type;

   typedef struct packed {
      logic [6:0] symbol;
      logic       last;
      logic       range_error;
   } letter_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [11:0] req_value;
   logic        rsp_valid;
   logic [6:0]  rsp_symbol;
   logic        rsp_last;
   logic        rsp_range_error;

   letter_type pending_letters[$];
   int         mismatches    = 0;
   int         letters_seen  = 0;
   int         values_sent   = 0;
   int         values_range  = 0;
   int         cycle_count   = 0;

   // Directed table: value, how its letters are known, and the numeral where typed in.
   logic [11:0] dir_value [N_DIRECTED] = '{
      12'd0,    12'd1,    12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd3000, 12'd4,
      12'd9,    12'd5,    12'd8,    12'd40,   12'd90,   12'd50,   12'd400,  12'd900,
      12'd500,  12'd1994, 12'd2048, 12'd1365, 12'd2730, 12'd3};
   row_kind_type dir_kind [N_DIRECTED] = '{
      ROW_RANGE_ERROR, ROW_NUMERAL, ROW_NUMERAL, ROW_RANGE_ERROR, ROW_RANGE_ERROR,
      ROW_NUMERAL, ROW_NUMERAL, ROW_PREDICT, ROW_PREDICT, ROW_PREDICT, ROW_PREDICT,
      ROW_PREDICT, ROW_PREDICT, ROW_PREDICT, ROW_PREDICT, ROW_PREDICT, ROW_PREDICT,
      ROW_PREDICT, ROW_PREDICT, ROW_PREDICT, ROW_PREDICT, ROW_PREDICT};
   string dir_numeral [N_DIRECTED] = '{
      "", "I", "MMMCMXCIX", "", "", "MMMDCCCLXXXVIII", "MMM", "", "", "", "",
      "", "", "", "", "", "", "", "", "", "", ""};

   roman_numeral_encoder DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_symbol      (rsp_symbol),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Works out the letters of one value and queues them in reading order.
   function automatic void predict_numeral(input logic [11:0] value);
      logic [6:0] word[$];
      letter_type item;
      int         scale;
      int         digit;
      if (value == 12'd0 || value > MAX_VALUE) begin
         item.symbol      = SYM_NONE;
         item.last        = 1'b1;
         item.range_error = 1'b1;
         pending_letters.push_back(item);
         return;
      end
      scale = 1000;
      for (int dec = 3; dec >= 0; dec--) begin
         digit = (int'(value) / scale) % 10;
         scale = scale / 10;
         if (digit == 9) begin
            word.push_back(ONE_LETTERS[dec*7 +: 7]);
            word.push_back(TEN_LETTERS[dec*7 +: 7]);
         end else if (digit == 4) begin
            word.push_back(ONE_LETTERS[dec*7 +: 7]);
            word.push_back(FIVE_LETTERS[dec*7 +: 7]);
         end else begin
            if (digit >= 5)
               word.push_back(FIVE_LETTERS[dec*7 +: 7]);
            repeat (digit % 5) word.push_back(ONE_LETTERS[dec*7 +: 7]);
         end
      end
      foreach (word[i]) begin
         item.symbol      = word[i];
         item.last        = (i == word.size() - 1);
         item.range_error = 1'b0;
         pending_letters.push_back(item);
      end
   endfunction

   // Presents one value and waits for its transfer; returns at the accepting edge.
   task automatic send_value(input logic [11:0] value);
      @(negedge clock);
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      values_sent++;
      if (value == 12'd0 || value > MAX_VALUE)
         values_range++;
   endtask

   // Compares every strobed letter with the oldest one still expected.
   always @(posedge clock) begin
      letter_type want;
      if (!reset && rsp_valid) begin
         letters_seen++;
         if (pending_letters.size() == 0) begin
            $error("rsp_symbol: no letter expected, got %h", rsp_symbol);
            mismatches++;
         end else begin
            want = pending_letters.pop_front();
            if (rsp_symbol !== want.symbol) begin
               $error("rsp_symbol: expected %h, got %h", want.symbol, rsp_symbol);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %b, got %b", want.last, rsp_last);
               mismatches++;
            end
            if (rsp_range_error !== want.range_error) begin
               $error("rsp_range_error: expected %b, got %b",
                      want.range_error, rsp_range_error);
               mismatches++;
            end
         end
      end
   end

   // Guards against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out with %0d letters still expected.", pending_letters.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      string       numeral;
      byte         ch;
      letter_type  item;
      logic [11:0] value;
      int          pct;
      int          sel;

      reset     = 1'b1;
      start     = 1'b0;
      req_value = 12'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, back to back: extremes, every digit pattern and the range errors.
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_value(dir_value[i]);
         unique case (dir_kind[i])
            ROW_RANGE_ERROR: begin
               item.symbol      = SYM_NONE;
               item.last        = 1'b1;
               item.range_error = 1'b1;
               pending_letters.push_back(item);
            end
            ROW_NUMERAL: begin
               numeral = dir_numeral[i];
               for (int k = 0; k < numeral.len(); k++) begin
                  ch               = numeral[k];
                  item.symbol      = ch[6:0];
                  item.last        = (k == numeral.len() - 1);
                  item.range_error = 1'b0;
                  pending_letters.push_back(item);
               end
            end
            default: predict_numeral(dir_value[i]);
         endcase
      end

      // Random part: one phase without gaps, one mostly idle, one lightly idle, one without.
      for (int phase = 0; phase < N_PHASES; phase++) begin
         pct = (phase == 1) ? 83 : ((phase == 2) ? 9 : 0);
         for (int n = 0; n < VALUES_PER_PHASE; n++) begin
            // Idle cycles carry noise on the value port, which must be ignored.
            while ($urandom_range(99) < pct) begin
               @(negedge clock);
               start     <= 1'b0;
               req_value <= 12'($urandom_range(4095));
            end
            sel = $urandom_range(99);
            if (sel < 75)
               value = 12'($urandom_range(int'(MAX_VALUE), 1));
            else if (sel < 85)
               value = 12'($urandom_range(4095));
            else if (sel < 90)
               value = 12'd0;
            else
               value = 12'($urandom_range(4095, int'(MAX_VALUE) + 1));
            send_value(value);
            predict_numeral(value);
         end
      end

      @(negedge clock);
      start <= 1'b0;

      // Let the last numerals come out, then watch for stray letters.
      while (pending_letters.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d values, %0d of them out of range, and checked %0d letters",
               values_sent, values_range, letters_seen);
      $display("over directed values and %0d idling phases.", N_PHASES);
      if (mismatches == 0 && pending_letters.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
